/* rtl/core/lkv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared sizes, operation codes, storage vector types and the structs that
// pass between the match logic, the entry store and the top level.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int WORD_W      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // operation codes carried by the kind field
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef logic [SLOT_W-1:0]                   slot_t;
    typedef logic [CNT_W-1:0]                    cnt_t;
    typedef logic [WORD_W-1:0]                   word_t;
    typedef logic [MAX_ENTRIES-1:0]              flag_vec_t;
    typedef logic [MAX_ENTRIES-1:0][WORD_W-1:0]  word_vec_t;
    typedef logic [MAX_ENTRIES-1:0][SLOT_W-1:0]  rank_vec_t;

    // lookup outcome for the item in the input register
    typedef struct packed {
        logic  hit;
        slot_t hit_slot;
        slot_t victim_slot;
        slot_t free_slot;
    } match_t;

    // one update of the entry store
    typedef struct packed {
        logic  touch;        // make slot most recent
        logic  write_key;
        logic  write_value;
        logic  grow;         // claim a free slot, all valid entries age
        slot_t slot;
        slot_t limit;        // entries newer than this rank age by one
        word_t key;
        word_t value;
    } upd_t;

endpackage

/* rtl/core/lkv_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache match logic
// Parallel key compare, least recent victim pick and free slot pick.
// ----------------------------------------------------------------------------
module lkv_match
(
    input  lkv_pkg::word_vec_t keys,
    input  lkv_pkg::flag_vec_t valid,
    input  lkv_pkg::rank_vec_t ranks,
    input  lkv_pkg::cnt_t      occupancy,
    input  lkv_pkg::word_t     key,
    output lkv_pkg::match_t    result
);

    lkv_pkg::flag_vec_t hit_vec;
    lkv_pkg::flag_vec_t old_vec;
    lkv_pkg::slot_t     oldest_rank;
    lkv_pkg::cnt_t      occ_minus_one;

    // the least recent valid entry holds rank occupancy - 1
    assign occ_minus_one = occupancy - lkv_pkg::CNT_W'(1);
    assign oldest_rank   = occ_minus_one[lkv_pkg::SLOT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        begin
            hit_vec[i] = valid[i] && (keys[i] == key);
            old_vec[i] = valid[i] && (ranks[i] == oldest_rank);
        end
    end

    // lowest index wins in each encoder
    always_comb
    begin
        result = '0;
        result.hit = |hit_vec;
        for (int i = lkv_pkg::MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                result.hit_slot = lkv_pkg::SLOT_W'(i);
            end
            if (old_vec[i])
            begin
                result.victim_slot = lkv_pkg::SLOT_W'(i);
            end
            if (!valid[i])
            begin
                result.free_slot = lkv_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

/* rtl/core/lkv_entries.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache entry store
// Keys, values, valid bits, recency ranks and occupancy, with one update
// applied per cycle.
// ----------------------------------------------------------------------------
module lkv_entries
(
    input  logic               clk,
    input  logic               rst_n,
    input  lkv_pkg::upd_t      upd,
    output lkv_pkg::word_vec_t keys,
    output lkv_pkg::word_vec_t values,
    output lkv_pkg::flag_vec_t valid,
    output lkv_pkg::rank_vec_t ranks,
    output lkv_pkg::cnt_t      occupancy
);

    lkv_pkg::word_vec_t keys_reg,   keys_next;
    lkv_pkg::word_vec_t values_reg, values_next;
    lkv_pkg::flag_vec_t valid_reg,  valid_next;
    lkv_pkg::rank_vec_t rank_reg,   rank_next;
    lkv_pkg::cnt_t      occ_reg,    occ_next;

    always_comb
    begin
        keys_next   = keys_reg;
        values_next = values_reg;
        valid_next  = valid_reg;
        rank_next   = rank_reg;
        occ_next    = occ_reg;
        if (upd.touch)
        begin
            // age the entries that were newer than the touched one, or every valid entry on a grow
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
            begin
                if (valid_reg[i] && (upd.grow || (rank_reg[i] < upd.limit)))
                begin
                    rank_next[i] = rank_reg[i] + lkv_pkg::SLOT_W'(1);
                end
            end
            rank_next[upd.slot] = '0;
            if (upd.write_key)
            begin
                keys_next[upd.slot] = upd.key;
            end
            if (upd.write_value)
            begin
                values_next[upd.slot] = upd.value;
            end
            if (upd.grow)
            begin
                valid_next[upd.slot] = 1'b1;
                occ_next             = occ_reg + lkv_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rank_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg   <= keys_next;
        values_reg <= values_next;
    end

    assign keys      = keys_reg;
    assign values    = values_reg;
    assign valid     = valid_reg;
    assign ranks     = rank_reg;
    assign occupancy = occ_reg;

endmodule

/* rtl/core/lru_key_value_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative key-value store with least-recently-used replacement
// and a programmable capacity.
// ----------------------------------------------------------------------------
//
//  channel   signals                      role
//  --------  ---------------------------  --------------------------------
//  request   req_valid req_stall kind     get (lookup) or put (insert or
//            key value                    update) beat into the cache
//  response  rsp_valid rsp_stall found    one beat per get: hit flag and
//            data                         stored value (zero on a miss)
//  config    cfg_write cfg_wdata          capacity register, write only
//
//  A beat lands in the input register, where it is looked up; it is
//  applied to the entry store as it leaves, and a get result is loaded
//  into the response register at the same edge. One beat per cycle is
//  sustained unless a stalled response holds a get, since the compare
//  and rank update over all entries are combinational.
//  Reset clears every valid bit, rank and the occupancy, and sets capacity
//  to 16. A stalled response holds a pending get in the input register;
//  a put in the input register still drains because it gives no response.
//
module lru_key_value_cache_core
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            kind,
    input  logic signed [lkv_pkg::WORD_W-1:0] key,
    input  logic signed [lkv_pkg::WORD_W-1:0] value,

    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            found,
    output logic signed [lkv_pkg::WORD_W-1:0] data,

    input  logic                            cfg_write,
    input  logic [lkv_pkg::CAP_W-1:0]       cfg_wdata
);

    // capacity register
    logic [lkv_pkg::CAP_W-1:0] cap_reg, cap_next;
    lkv_pkg::cnt_t             eff_cap;

    // input register
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_kind_reg,  s1_kind_next;
    lkv_pkg::word_t s1_key_reg,  s1_key_next;
    lkv_pkg::word_t s1_value_reg, s1_value_next;

    // response register
    logic          rsp_valid_reg, rsp_valid_next;
    logic          rsp_found_reg, rsp_found_next;
    lkv_pkg::word_t rsp_data_reg, rsp_data_next;

    // store view and lookup
    lkv_pkg::word_vec_t ent_keys;
    lkv_pkg::word_vec_t ent_values;
    lkv_pkg::flag_vec_t ent_valid;
    lkv_pkg::rank_vec_t ent_ranks;
    lkv_pkg::cnt_t      ent_occ;
    lkv_pkg::match_t    mt;
    lkv_pkg::upd_t      upd;
    lkv_pkg::cnt_t      occ_minus_one;

    logic req_take;
    logic s1_go;
    logic s1_act;
    logic is_put;
    logic evict;

    // ------------------------------------------------------------------
    // Capacity: zero means one, anything above the store size saturates
    // ------------------------------------------------------------------
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_write)
        begin
            cap_next = cfg_wdata;
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = lkv_pkg::CNT_W'(1);
        end
        else if (int'(cap_reg) > lkv_pkg::MAX_ENTRIES)
        begin
            eff_cap = lkv_pkg::CNT_W'(lkv_pkg::MAX_ENTRIES);
        end
        else
        begin
            eff_cap = lkv_pkg::CNT_W'(cap_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake: a put always advances; a get advances only when the
    // response register is free or being emptied this cycle
    // ------------------------------------------------------------------
    assign is_put    = (s1_kind_reg == lkv_pkg::KIND_PUT);
    assign s1_go     = is_put || !rsp_valid_reg || !rsp_stall;
    assign s1_act    = s1_valid_reg && s1_go;
    assign req_stall = s1_valid_reg && !s1_go;
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_kind_next  = s1_kind_reg;
        s1_key_next   = s1_key_reg;
        s1_value_next = s1_value_reg;
        if (req_take)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = kind;
            s1_key_next   = key;
            s1_value_next = value;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Lookup against the current store contents
    // ------------------------------------------------------------------
    lkv_match u_match
    (
        .keys      (ent_keys),
        .valid     (ent_valid),
        .ranks     (ent_ranks),
        .occupancy (ent_occ),
        .key       (s1_key_reg),
        .result    (mt)
    );

    assign evict         = (ent_occ >= eff_cap);
    assign occ_minus_one = ent_occ - lkv_pkg::CNT_W'(1);

    // ------------------------------------------------------------------
    // Store update: hit touches, put miss either evicts the least recent
    // entry in place or claims a free slot
    // ------------------------------------------------------------------
    always_comb
    begin
        upd             = '0;
        upd.key         = s1_key_reg;
        upd.value       = s1_value_reg;
        upd.touch       = s1_act && (mt.hit || is_put);
        upd.write_key   = is_put && !mt.hit;
        upd.write_value = is_put;
        upd.grow        = is_put && !mt.hit && !evict;
        if (mt.hit)
        begin
            upd.slot  = mt.hit_slot;
            upd.limit = ent_ranks[mt.hit_slot];
        end
        else if (evict)
        begin
            upd.slot  = mt.victim_slot;
            upd.limit = occ_minus_one[lkv_pkg::SLOT_W-1:0];
        end
        else
        begin
            upd.slot  = mt.free_slot;
            upd.limit = '0;
        end
    end

    lkv_entries u_entries
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .keys      (ent_keys),
        .values    (ent_values),
        .valid     (ent_valid),
        .ranks     (ent_ranks),
        .occupancy (ent_occ)
    );

    // ------------------------------------------------------------------
    // Response register: load a get result, drop the beat once taken
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_found_next = rsp_found_reg;
        rsp_data_next  = rsp_data_reg;
        if (s1_act && !is_put)
        begin
            rsp_valid_next = 1'b1;
            rsp_found_next = mt.hit;
            rsp_data_next  = mt.hit ? ent_values[mt.hit_slot] : '0;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkv_pkg::CAP_RESET;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg   <= s1_kind_next;
        s1_key_reg    <= s1_key_next;
        s1_value_reg  <= s1_value_next;
        rsp_found_reg <= rsp_found_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign found     = rsp_found_reg;
    assign data      = rsp_data_reg;

endmodule
